[sv/ptbt_pkg.sv]
// Shared types and codes for the periodic token bucket throttle unit.
`timescale 1ns / 1ps

package ptbt_pkg;

    localparam int CREDIT_W  = 25;
    localparam int ELAPSED_W = 21;
    localparam int CAP_W     = 24;
    localparam int PERIOD_W  = 20;
    localparam int THRESH_W  = 16;
    localparam int BYTES_W   = 16;
    localparam int GROUP_W   = 32;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [CREDIT_W-1:0]  CREDIT_MAX  = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    localparam logic [CAP_W-1:0]    CAP_RESET    = '0;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1500);

    typedef enum logic [2:0] {
        REG_BUCKET_CAPACITY = 3'd0,
        REG_PERIOD_TICKS    = 3'd1,
        REG_CARRY_THRESHOLD = 3'd2,
        REG_FILL_INITIALLY  = 3'd3,
        REG_ENABLED         = 3'd4
    } t_reg_index;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_REQUEST = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_ERROR   = 2'd1,
        ST_BUSY    = 2'd2
    } t_status;

    typedef struct packed {
        logic               op;
        logic [BYTES_W-1:0] request_bytes;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [GROUP_W-1:0] group_number;
    } t_out_item;

endpackage

[sv/periodic_token_bucket_throttle_unit.sv]
// Top level of the periodic token bucket throttle unit.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+----------------------------------
// input     | in        | i_valid / o_stall      | i_data  (op, request_bytes)
// output    | out       | o_valid / i_stall      | o_data  (status, group_number)
// config    | in        | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// One transaction per cycle unless the consumer stalls: an accepted transaction
// lands in the input register, and once the result register can take it, is resolved
// against the bucket state and any result is written to the result register. The single
// bucket state update per resolved transaction sets the rate at one transaction per clock.
// Reset (synchronous, active low) clears bucket state and restores registers.
// o_stall rises only while the input register is full and the result register
// is held by a stalled consumer.

module periodic_token_bucket_throttle_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  ptbt_pkg::t_in_item         i_data,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output ptbt_pkg::t_out_item        o_data,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ptbt_pkg::ADDR_W-1:0] paddr,
    input  logic [ptbt_pkg::DATA_W-1:0] pwdata,
    output logic [ptbt_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import ptbt_pkg::*;

    // configuration registers
    logic [CAP_W-1:0]    r_capacity;
    logic [PERIOD_W-1:0] r_period;
    logic [THRESH_W-1:0] r_threshold;
    logic                r_fill_init;
    logic                r_enabled;

    // bucket state
    logic [CREDIT_W-1:0]  r_credit;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [GROUP_W-1:0]   r_group;
    logic                 r_pending_valid;
    logic [BYTES_W-1:0]   r_pending_bytes;

    // input and result registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic       w_proc_go;
    logic       w_proc;
    logic       w_cfg_wr;
    t_reg_index w_reg_idx;

    logic                 w_is_tick;
    logic                 w_uses_bucket;
    logic [ELAPSED_W-1:0] w_elapsed_inc;
    logic [ELAPSED_W-1:0] w_elapsed_base;
    logic                 w_due;
    logic                 w_refill;
    logic [CREDIT_W:0]    w_sum;
    logic [CREDIT_W-1:0]  w_credit_ref;
    logic [GROUP_W-1:0]   w_group_ref;
    logic [BYTES_W-1:0]   w_bytes;
    logic                 w_fits;
    logic                 w_has_result;
    t_out_item            w_result;
    logic signed [CREDIT_W+1:0] w_shift;
    logic [CREDIT_W-1:0]  w_credit_shift;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_index'(paddr[ADDR_W-1:2]);

    // advance the input register whenever the result register can take a result
    assign w_proc_go = !r_out_valid || !i_stall;
    assign w_proc    = r_in_valid && w_proc_go;
    assign o_stall   = r_in_valid && !w_proc_go;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // read back
    always_comb begin
        prdata = '0;
        case (w_reg_idx)
            REG_BUCKET_CAPACITY: prdata = DATA_W'(r_capacity);
            REG_PERIOD_TICKS:    prdata = DATA_W'(r_period);
            REG_CARRY_THRESHOLD: prdata = DATA_W'(r_threshold);
            REG_FILL_INITIALLY:  prdata = DATA_W'(r_fill_init);
            REG_ENABLED:         prdata = DATA_W'(r_enabled);
            default:             prdata = '0;
        endcase
    end

    // Resolve the transaction in the input register against the bucket.
    // A tick touches the bucket only when a request waits; a new request touches
    // it only when enabled and nothing waits.
    always_comb begin
        w_is_tick      = (r_in.op == OP_TICK);
        w_elapsed_inc  = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;
        w_elapsed_base = w_is_tick ? w_elapsed_inc : r_elapsed;
        w_uses_bucket  = w_is_tick ? r_pending_valid : (r_enabled && !r_pending_valid);
        w_due          = w_elapsed_base > ELAPSED_W'(r_period);
        w_refill       = w_uses_bucket && w_due;

        // refill: add when below the carry threshold, else reload
        w_sum = (CREDIT_W+1)'(r_credit) + (CREDIT_W+1)'(r_capacity);
        if (!w_due) begin
            w_credit_ref = r_credit;
        end else if (r_credit < CREDIT_W'(r_threshold)) begin
            w_credit_ref = w_sum[CREDIT_W] ? CREDIT_MAX : w_sum[CREDIT_W-1:0];
        end else begin
            w_credit_ref = CREDIT_W'(r_capacity);
        end
        w_group_ref = w_due ? r_group + 1'b1 : r_group;

        w_bytes = w_is_tick ? r_pending_bytes : r_in.request_bytes;
        w_fits  = CREDIT_W'(w_bytes) <= w_credit_ref;

        w_result     = '0;
        w_has_result = 1'b0;
        if (w_is_tick) begin
            if (r_pending_valid && w_fits) begin
                w_has_result        = 1'b1;
                w_result.status     = ST_GRANTED;
                w_result.group_number = w_group_ref;
            end
        end else if (!r_enabled) begin
            w_has_result    = 1'b1;
            w_result.status = ST_ERROR;
        end else if (r_pending_valid) begin
            w_has_result    = 1'b1;
            w_result.status = ST_BUSY;
        end else if (w_fits) begin
            w_has_result        = 1'b1;
            w_result.status     = ST_GRANTED;
            w_result.group_number = w_group_ref;
        end
    end

    // capacity write shifts credit by the change, clamped to the credit range
    always_comb begin
        w_shift = $signed({2'b00, r_credit})
                + $signed({3'b000, pwdata[CAP_W-1:0]})
                - $signed({3'b000, r_capacity});
        if (w_shift < 0) begin
            w_credit_shift = '0;
        end else if (w_shift > $signed({2'b00, CREDIT_MAX})) begin
            w_credit_shift = CREDIT_MAX;
        end else begin
            w_credit_shift = w_shift[CREDIT_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_period    <= PERIOD_RESET;
            r_threshold <= THRESH_RESET;
            r_fill_init <= 1'b1;
            r_enabled   <= 1'b1;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_BUCKET_CAPACITY: r_capacity  <= pwdata[CAP_W-1:0];
                REG_PERIOD_TICKS:    r_period    <= pwdata[PERIOD_W-1:0];
                REG_CARRY_THRESHOLD: r_threshold <= pwdata[THRESH_W-1:0];
                REG_FILL_INITIALLY:  r_fill_init <= pwdata[0];
                REG_ENABLED:         r_enabled   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // bucket state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit        <= '0;
            r_elapsed       <= '0;
            r_group         <= '0;
            r_pending_valid <= 1'b0;
        end else if (w_cfg_wr && w_reg_idx == REG_BUCKET_CAPACITY) begin
            if (r_fill_init) begin
                r_credit <= w_credit_shift;
            end
        end else if (w_proc) begin
            if (w_is_tick) begin
                r_elapsed <= w_refill ? '0 : w_elapsed_inc;
            end else if (w_refill) begin
                r_elapsed <= '0;
            end
            if (w_uses_bucket) begin
                r_credit <= w_fits ? w_credit_ref - CREDIT_W'(w_bytes) : w_credit_ref;
                r_group  <= w_group_ref;
                // grant clears a waiting request; a misfit request starts waiting
                r_pending_valid <= !w_fits;
            end
        end
    end

    // waiting request bytes need no reset
    always_ff @(posedge i_clk) begin
        if (w_proc && !w_is_tick && w_uses_bucket && !w_fits) begin
            r_pending_bytes <= r_in.request_bytes;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc_go) begin
            r_out_valid <= w_proc && w_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_has_result) begin
            r_out <= w_result;
        end
    end

    // group number moves by at most one per cycle
    a_group_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_group == $past(r_group)) || (r_group == $past(r_group) + 1'b1))
        else $error("group number jumped");

    // a tick that grants the waiting request clears it
    a_tick_grant_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_is_tick && r_pending_valid && w_fits && !w_cfg_wr)
        |=> !r_pending_valid)
        else $error("waiting request not cleared by grant");

    // credit never grows without a refill or a capacity write
    a_credit_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_cfg_wr && !(w_proc && w_refill)) |=> (r_credit <= $past(r_credit)))
        else $error("credit grew without refill");

    // input side stalls only with a held transaction
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("stall without a held transaction");

endmodule
